[rtl/core/qprg_pkg.sv]
// Package: types, constants and commands shared by the generator modules.
`timescale 1ns / 1ps
package qprg_pkg;

   localparam logic [31:0] QPR_PRIME = 32'hFFFF_FFFB;
   localparam logic [31:0] QPR_HALF  = 32'h7FFF_FFFD;
   localparam logic [31:0] QPR_XOR   = 32'h5BF0_3635;
   localparam int          MIX_ROUNDS = 4;
   localparam int          SEED_COUNT = 8;

   localparam logic [2:0] ACT_RESEED = 3'd0;
   localparam logic [2:0] ACT_GEN32  = 3'd1;
   localparam logic [2:0] ACT_UNIQUE = 3'd2;
   localparam logic [2:0] ACT_GEN64  = 3'd3;
   localparam logic [2:0] ACT_RANGE  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_REDUCE,
      ST_FOLD,
      ST_MIX,
      ST_WORD_END,
      ST_CHECK,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       start_chain;
      logic       square;
      logic       reduce;
      logic       fold;
      logic       mix;
      logic       word_end;
      logic       check;
      logic       div_start;
      logic       div_step;
      logic       finish;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       lane_last;
      logic       round_last;
      logic       word_last;
      logic       range_bad;
      logic       div_done;
   } status_type;

endpackage

[rtl/core/qprg_datapath.sv]
// Datapath: offset words, modular square unit, 64-bit divider and result word.
`timescale 1ns / 1ps
module qprg_datapath #(
   parameter int NUM_OFFSETS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  qprg_pkg::cmd_type   cmd,
   output qprg_pkg::status_type status,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  logic [2:0]          act,
   input  logic [63:0]         range_low,
   input  logic [63:0]         range_high,
   output logic [63:0]         rsp_random_bits,
   output logic [63:0]         rsp_range_value,
   output logic                rsp_range_error
);
   import qprg_pkg::*;

   localparam int LW = (NUM_OFFSETS > 1) ? $clog2(NUM_OFFSETS) : 1;

   logic [31:0] seed_ff [SEED_COUNT];
   logic [31:0] off_ff [NUM_OFFSETS];
   logic [31:0] last_ff;
   logic [31:0] x_ff;
   logic [63:0] sq_ff;
   logic [33:0] red_ff;
   logic [31:0] q_ff;
   logic        big_ff, pass_ff;
   logic [LW-1:0] lane_ff;
   logic [1:0]  round_ff;
   logic        word_ff;
   logic        carry_ff;
   logic [63:0] bits_ff;
   logic [63:0] span_ff, num_ff, rem_ff;
   logic [6:0]  dcnt_ff;
   logic        neg_ff, bad_ff;
   logic [63:0] rb_ff, rv_ff;
   logic        re_ff;

   logic [31:0] off_cur, mixed, off_inc;
   logic [34:0] fold1;
   logic [33:0] red_in;
   logic [64:0] rem_sh;
   logic [63:0] span_in, r_fix;
   logic [63:0] bits_cur;
   logic        hneg, lneg, rev;

   assign off_cur = off_ff[lane_ff];
   assign mixed   = (q_ff + off_cur) ^ QPR_XOR;
   assign off_inc = off_cur + 32'd1;
   // 2^32 = 5 mod P: fold the high half twice
   assign fold1   = {3'd0, sq_ff[31:0]} + {1'b0, sq_ff[63:32], 2'b00}
                    + {3'd0, sq_ff[63:32]};
   assign red_in  = {2'd0, fold1[31:0]} + ({31'd0, fold1[34:32]} * 34'd5);
   assign rem_sh  = {rem_ff, num_ff[63]};
   assign span_in = range_high - range_low + 64'd1;
   assign hneg    = range_high[63];
   assign lneg    = range_low[63];
   assign rev     = (hneg != lneg) ? hneg : (range_high < range_low);
   assign r_fix   = (neg_ff && rem_ff != 64'd0) ? span_ff - rem_ff : rem_ff;
   assign bits_cur = cmd.word_end ? {bits_ff[31:0], x_ff} : bits_ff;

   assign status.lane_last  = (lane_ff == LW'(NUM_OFFSETS - 1));
   assign status.round_last = (round_ff == 2'(MIX_ROUNDS - 1));
   assign status.word_last  = word_ff;
   assign status.range_bad  = bad_ff;
   assign status.div_done   = (dcnt_ff == 7'd64);

   assign rsp_random_bits = rb_ff;
   assign rsp_range_value = rv_ff;
   assign rsp_range_error = re_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEED_COUNT; i++) seed_ff[i] <= 32'd0;
         seed_ff[3] <= 32'd1;
         for (int i = 0; i < NUM_OFFSETS; i++) off_ff[i] <= 32'd0;
         last_ff <= 32'd0;
      end else begin
         if (csr_write) seed_ff[csr_index] <= csr_data;
         if (cmd.start_chain && act == ACT_RESEED) begin
            for (int i = 0; i < NUM_OFFSETS; i++) off_ff[i] <= seed_ff[i];
            last_ff <= 32'd0;
         end
         if (cmd.mix) begin
            if (act == ACT_RESEED) off_ff[lane_ff] <= mixed;
            else if (act != ACT_UNIQUE && carry_ff) off_ff[lane_ff] <= off_inc;
         end
         if (cmd.word_end) begin
            if (act == ACT_UNIQUE) last_ff <= last_ff + 32'd1;
            else if (act != ACT_RESEED) last_ff <= x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= 1'b0;
         bits_ff <= 64'd0;
      end
      if (cmd.start_chain) begin
         x_ff     <= (act == ACT_RESEED) ? 32'd0 : last_ff;
         lane_ff  <= '0;
         round_ff <= 2'd0;
         carry_ff <= 1'b1;
         span_ff  <= span_in;
         bad_ff   <= rev || span_in == 64'd0 || span_in[63];
      end
      if (cmd.square) begin
         sq_ff   <= x_ff * x_ff;
         pass_ff <= (x_ff >= QPR_PRIME);
         big_ff  <= (x_ff > QPR_HALF);
      end
      if (cmd.reduce) red_ff <= red_in;
      if (cmd.fold) begin
         if (pass_ff) q_ff <= x_ff;
         else if (red_ff >= {2'd0, QPR_PRIME})
            q_ff <= big_ff ? QPR_PRIME - (red_ff[31:0] - QPR_PRIME) : red_ff[31:0] - QPR_PRIME;
         else q_ff <= big_ff ? QPR_PRIME - red_ff[31:0] : red_ff[31:0];
      end
      if (cmd.mix) begin
         x_ff <= mixed;
         if (carry_ff) carry_ff <= (off_inc == 32'd0);
         if (status.lane_last) begin
            lane_ff  <= '0;
            round_ff <= round_ff + 2'd1;
         end else begin
            lane_ff <= lane_ff + LW'(1);
         end
      end
      if (cmd.word_end) begin
         bits_ff <= {bits_ff[31:0], x_ff};
         word_ff <= 1'b1;
      end
      if (cmd.div_start) begin
         neg_ff  <= bits_ff[63];
         num_ff  <= bits_ff[63] ? 64'd0 - bits_ff : bits_ff;
         rem_ff  <= 64'd0;
         dcnt_ff <= 7'd0;
      end
      if (cmd.div_step) begin
         num_ff  <= {num_ff[62:0], 1'b0};
         rem_ff  <= (rem_sh >= {1'b0, span_ff}) ? 64'(rem_sh - {1'b0, span_ff})
                                               : rem_sh[63:0];
         dcnt_ff <= dcnt_ff + 7'd1;
      end
      if (cmd.finish) rv_ff <= range_low + r_fix;
      if (cmd.rsp_load) begin
         re_ff <= 1'b0;
         rb_ff <= 64'd0;
         rv_ff <= 64'd0;
         if (act == ACT_GEN32 || act == ACT_UNIQUE) rb_ff <= {32'd0, bits_cur[31:0]};
         else if (act == ACT_GEN64 || act == ACT_RANGE) rb_ff <= bits_cur;
         if (act == ACT_RANGE) begin
            re_ff <= bad_ff;
            if (!bad_ff) rv_ff <= range_low + r_fix;
         end
      end
   end
endmodule

[rtl/core/qprg_control.sv]
// Controller: sequences the mixing chain, divider and result handshake.
`timescale 1ns / 1ps
module qprg_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [2:0]           act,
   input  qprg_pkg::status_type status,
   output qprg_pkg::cmd_type    cmd
);
   import qprg_pkg::*;

   state_type state_ff, state_in;
   logic is_chain, two_words;

   assign is_chain  = (act == ACT_RESEED || act == ACT_GEN32 || act == ACT_UNIQUE
                       || act == ACT_GEN64 || act == ACT_RANGE);
   assign two_words = (act == ACT_GEN64 || act == ACT_RANGE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LOAD;
         ST_LOAD:   state_in = is_chain ? ST_SQUARE : ST_OUT;
         ST_SQUARE: state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_MIX;
         ST_MIX: begin
            if (!status.lane_last) state_in = ST_SQUARE;
            else if (act == ACT_RESEED && !status.round_last) state_in = ST_SQUARE;
            else state_in = ST_WORD_END;
         end
         ST_WORD_END: begin
            if (two_words && !status.word_last) state_in = ST_LOAD;
            else if (act == ACT_RANGE) state_in = ST_CHECK;
            else state_in = ST_OUT;
         end
         ST_CHECK:  state_in = status.range_bad ? ST_OUT : ST_DIV;
         ST_DIV:    if (status.div_done) state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_LOAD:     cmd.start_chain = 1'b1;
         ST_SQUARE:   cmd.square = 1'b1;
         ST_REDUCE:   cmd.reduce = 1'b1;
         ST_FOLD:     cmd.fold = 1'b1;
         ST_MIX:      cmd.mix = 1'b1;
         ST_WORD_END: begin
            cmd.word_end = 1'b1;
            cmd.rsp_load = !(two_words && !status.word_last) && act != ACT_RANGE;
         end
         ST_CHECK: begin
            cmd.div_start = 1'b1;
            cmd.rsp_load  = status.range_bad;
         end
         ST_DIV: begin
            cmd.div_step = !status.div_done;
            cmd.rsp_load = status.div_done;
         end
         ST_OUT:      rsp_valid = 1'b1;
         default:     cmd = '0;
      endcase
      if (state_ff == ST_LOAD && !is_chain) cmd.rsp_load = 1'b1;
   end
endmodule

[rtl/core/qpr_chain_random_generator.sv]
// Top level: quadratic residue permutation random generator.
`timescale 1ns / 1ps
// Usage:
//   req channel: req_valid/req_stall carry one word (action, range bounds).
//   rsp channel: rsp_valid/rsp_stall return exactly one word per request.
//   csr port: csr_write with csr_index 0..7 loads seed words; write while idle.
// Sequence: each permutation step runs square, reduce, fold and add offset,
//   and one 32-bit chain runs one step per offset word. Range requests
//   follow the gen64 chains with a span check and a 64-step restoring
//   divider.
// Throughput: one request at a time; the next request is taken the cycle
//   after the response word is delivered.
// Reset: offsets and last value clear, seed word 3 is 1, the others 0.
// Stall: the response word holds in its output register while rsp_stall
//   is high; req_stall stays high until it leaves.
module qpr_chain_random_generator #(
   parameter int NUM_OFFSETS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic signed [63:0] req_range_low,
   input  logic signed [63:0] req_range_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_random_bits,
   output logic signed [63:0] rsp_range_value,
   output logic        rsp_range_error,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import qprg_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [2:0] act_ff;
   logic [63:0] low_ff, high_ff;
   logic [63:0] rv;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         low_ff  <= req_range_low;
         high_ff <= req_range_high;
      end
   end

   qprg_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .act(act_ff), .status, .cmd
   );

   qprg_datapath #(.NUM_OFFSETS(NUM_OFFSETS)) u_dp (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .act(act_ff), .range_low(low_ff), .range_high(high_ff),
      .rsp_random_bits, .rsp_range_value(rv), .rsp_range_error
   );

   assign rsp_range_value = rv;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("request taken while response pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_random_bits))
      else $error("response changed under stall");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_range_value == 64'd0)
      else $error("range error with nonzero value");
endmodule

[verif/qpr_chain_random_generator_test.sv]
// Testbench: directed and random actions against a generator predictor, with csr phases.
`timescale 1ns / 1ps
module qpr_chain_random_generator_test;
   import qprg_pkg::*;

   typedef struct packed {
      logic [63:0]        bits;
      logic signed [63:0] value;
      logic               err;
   } gen_word_type;

   class gen_scoreboard;
      logic [31:0] seeds[8];
      logic [31:0] offs[8];
      logic [31:0] last;
      gen_word_type pending[$];
      int          errors;

      function new();
         for (int i = 0; i < 8; i++) begin
            seeds[i] = 0;
            offs[i] = 0;
         end
         seeds[3] = 1;
         last = 0;
         errors = 0;
      endfunction

      function logic [31:0] permute(logic [31:0] x, logic [31:0] off);
         logic [63:0] sq;
         logic [31:0] r;
         if (x >= QPR_PRIME) begin
            r = x;
         end else begin
            sq = ({32'd0, x} * {32'd0, x}) % {32'd0, QPR_PRIME};
            r = sq[31:0];
            if (x > QPR_PRIME / 2) r = QPR_PRIME - r;
         end
         return (r + off) ^ QPR_XOR;
      endfunction

      function logic [31:0] chain_step();
         logic [31:0] x;
         logic        carry;
         x = last;
         carry = 1;
         for (int i = 0; i < 8; i++) begin
            x = permute(x, offs[i]);
            if (carry) begin
               offs[i] = offs[i] + 1;
               carry = (offs[i] == 0);
            end
         end
         last = x;
         return x;
      endfunction

      function void note_request(logic [2:0] act, logic [63:0] lo, logic [63:0] hi);
         gen_word_type e;
         logic [31:0] x;
         logic [63:0] span, r;
         e = '0;
         case (act)
            ACT_RESEED: begin
               x = 0;
               last = 0;
               for (int i = 0; i < 8; i++) offs[i] = seeds[i];
               for (int k = 0; k < MIX_ROUNDS; k++)
                  for (int i = 0; i < 8; i++) begin
                     x = permute(x, offs[i]);
                     offs[i] = x;
                  end
            end
            ACT_GEN32: e.bits = {32'd0, chain_step()};
            ACT_UNIQUE: begin
               x = last;
               last = last + 1;
               for (int i = 0; i < 8; i++) x = permute(x, offs[i]);
               e.bits = {32'd0, x};
            end
            ACT_GEN64: begin
               e.bits[63:32] = chain_step();
               e.bits[31:0] = chain_step();
            end
            ACT_RANGE: begin
               e.bits[63:32] = chain_step();
               e.bits[31:0] = chain_step();
               span = hi - lo + 1;
               if ($signed(hi) < $signed(lo) || span == 0 || span[63]) begin
                  e.err = 1;
               end else begin
                  if (e.bits[63]) begin
                     r = (0 - e.bits) % span;
                     if (r != 0) r = span - r;
                  end else begin
                     r = e.bits % span;
                  end
                  e.value = lo + r;
               end
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      function void check_result(gen_word_type got);
         gen_word_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word bits %h", $time, got.bits);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.bits !== e.bits) begin
            $display("%0t: random_bits expected %h actual %h", $time, e.bits, got.bits);
            errors++;
         end
         if (got.value !== e.value) begin
            $display("%0t: range_value expected %h actual %h", $time, e.value, got.value);
            errors++;
         end
         if (got.err !== e.err) begin
            $display("%0t: range_error expected %b actual %b", $time, e.err, got.err);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [2:0]         req_action = 0;
   logic signed [63:0] req_range_low = 0;
   logic signed [63:0] req_range_high = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [63:0]        rsp_random_bits;
   logic signed [63:0] rsp_range_value;
   logic               rsp_range_error;
   logic               csr_write = 0;
   logic [2:0]         csr_index = 0;
   logic [31:0]        csr_data = 0;

   gen_scoreboard sb = new();
   int            cycle = 0;
   bit            hold_rsp = 0;
   localparam int LIMIT = 2000000;

   qpr_chain_random_generator u_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Accept result words and drive receiver stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_random_bits, rsp_range_value, rsp_range_error});
      if (hold_rsp) rsp_stall <= 1;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= ($urandom_range(0, 9) < 7);
      else rsp_stall <= 0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send(logic [2:0] act, logic [63:0] lo, logic [63:0] hi);
      req_valid <= 1;
      req_action <= act;
      req_range_low <= lo;
      req_range_high <= hi;
      do @(posedge clock); while (req_stall);
      sb.note_request(act, lo, hi);
      if ($urandom_range(0, 2) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_seed(logic [2:0] idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      sb.seeds[idx] = val;
   endtask

   task automatic send_random();
      logic [63:0] lo, hi;
      int          k;
      k = $urandom_range(0, 19);
      lo = rand64();
      hi = rand64();
      if (k < 8) begin
         lo = $signed($urandom_range(0, 2000)) - 1000;
         hi = lo + $urandom_range(0, 5000);
         if ($urandom_range(0, 5) == 0) hi = lo - $urandom_range(1, 50);
         send(ACT_RANGE, lo, hi);
      end else if (k == 8) send(ACT_RANGE, lo, hi);
      else if (k == 9) send(ACT_RESEED, lo, hi);
      else if (k == 10) send(3'($urandom_range(5, 7)), lo, hi);
      else send(3'($urandom_range(1, 3)), lo, hi);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(ACT_GEN32, 0, 0);
      send(ACT_UNIQUE, 0, 0);
      send(ACT_RESEED, 0, 0);
      send(ACT_GEN32, 0, 0);
      send(ACT_UNIQUE, 0, 0);
      send(ACT_UNIQUE, 0, 0);
      send(ACT_GEN64, 0, 0);
      send(ACT_RANGE, 0, 0);
      send(ACT_RANGE, 5, 4);
      send(ACT_RANGE, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      send(ACT_RANGE, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE);
      send(ACT_RANGE, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send(ACT_RANGE, 1, 64'h7FFF_FFFF_FFFF_FFFF);
      send(ACT_RANGE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      send(ACT_RANGE, -10, 10);
      send(3'd5, 0, 0);
      send(3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(3'd7, 0, 0);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 8; i++)
            write_seed(3'(i), ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 32'h0 :
                       ph == 2 ? QPR_PRIME - 1 + (i % 3) : $urandom());
         csr_write <= 0;
         send(ACT_RESEED, 0, 0);
         if (ph == 2) begin
            hold_rsp = 1;
            fork
               begin
                  repeat (400) @(posedge clock);
                  hold_rsp = 0;
               end
               for (int j = 0; j < 6; j++) send_random();
            join
         end
         for (int j = 0; j < 400; j++) send_random();
         drain();
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
